>>> design/kbc_pkg.sv
// Shared types, codes and state-update helpers of the PS/2 keyboard controller.
package kbc_pkg;

  localparam logic [2:0] OP_RD_STATUS = 3'd0;
  localparam logic [2:0] OP_RD_DATA   = 3'd1;
  localparam logic [2:0] OP_WR_CMD    = 3'd2;
  localparam logic [2:0] OP_WR_DATA   = 3'd3;
  localparam logic [2:0] OP_KBD_LEVEL = 3'd4;
  localparam logic [2:0] OP_AUX_LEVEL = 3'd5;

  localparam logic [7:0] CMD_NONE       = 8'h00;
  localparam logic [7:0] CMD_RD_MODE    = 8'h20;
  localparam logic [7:0] CMD_WR_MODE    = 8'h60;
  localparam logic [7:0] CMD_AUX_OFF    = 8'hA7;
  localparam logic [7:0] CMD_AUX_ON     = 8'hA8;
  localparam logic [7:0] CMD_AUX_TEST   = 8'hA9;
  localparam logic [7:0] CMD_SELF_TEST  = 8'hAA;
  localparam logic [7:0] CMD_KBD_TEST   = 8'hAB;
  localparam logic [7:0] CMD_KBD_OFF    = 8'hAD;
  localparam logic [7:0] CMD_KBD_ON     = 8'hAE;
  localparam logic [7:0] CMD_RD_INPORT  = 8'hC0;
  localparam logic [7:0] CMD_RD_OPORT   = 8'hD0;
  localparam logic [7:0] CMD_WR_OPORT   = 8'hD1;
  localparam logic [7:0] CMD_WR_KBD_OB  = 8'hD2;
  localparam logic [7:0] CMD_WR_AUX_OB  = 8'hD3;
  localparam logic [7:0] CMD_WR_AUX     = 8'hD4;
  localparam logic [7:0] CMD_A20_OFF    = 8'hDD;
  localparam logic [7:0] CMD_A20_ON     = 8'hDF;
  localparam logic [7:0] CMD_PULSE_BASE = 8'hF0;
  localparam logic [7:0] CMD_PULSE_NOP  = 8'hFF;
  localparam logic [7:0] CMD_PULSE_RST  = 8'hFE;

  localparam logic [7:0] SELF_TEST_OK = 8'h55;
  localparam logic [7:0] INPORT_VALUE = 8'h80;
  localparam logic [7:0] TEST_OK      = 8'h00;

  localparam logic [7:0] ST_OBF      = 8'h01;
  localparam logic [7:0] ST_SELFTEST = 8'h04;
  localparam logic [7:0] ST_AUXOBF   = 8'h20;
  localparam logic [7:0] MD_KBDINT   = 8'h01;
  localparam logic [7:0] MD_AUXINT   = 8'h02;
  localparam logic [7:0] MD_KBDOFF   = 8'h10;
  localparam logic [7:0] MD_AUXOFF   = 8'h20;
  localparam logic [7:0] OP_A20      = 8'h02;
  localparam logic [7:0] OP_OBF      = 8'h10;
  localparam logic [7:0] OP_AUXOBF   = 8'h20;
  localparam logic [5:0] PD_CKBD     = 6'h04;
  localparam logic [5:0] PD_CAUX     = 6'h08;
  localparam logic [5:0] PD_KBD      = 6'h10;
  localparam logic [5:0] PD_AUX      = 6'h20;
  localparam logic [2:0] SRC_KBD     = 3'h1;
  localparam logic [2:0] SRC_AUX     = 3'h2;
  localparam logic [2:0] SRC_CTL     = 3'h4;

  localparam logic [7:0] STATUS_RESET = 8'h18;
  localparam logic [7:0] MODE_RESET   = 8'h03;
  localparam logic [7:0] OPORT_RESET  = 8'hCF;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       line_level;
    logic [7:0] kbd_byte;
    logic [7:0] mouse_byte;
  } kbc_in_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       kbd_irq;
    logic       aux_irq;
    logic       a20_line;
    logic       reset_request;
    logic       kbd_send_valid;
    logic       mouse_send_valid;
    logic [7:0] send_byte;
    logic       kbd_fetch;
    logic       mouse_fetch;
    logic       translate_enable;
  } kbc_out_t;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] mode;
    logic [7:0] oport;
    logic [5:0] pend;
    logic [7:0] awaited;
    logic [2:0] src;
    logic [7:0] buf_byte;
    logic [7:0] reply;
    logic       line_kbd;
    logic       line_aux;
  } kbc_state_t;

  localparam kbc_state_t STATE_RESET = '{
    status: STATUS_RESET, mode: MODE_RESET, oport: OPORT_RESET, pend: '0,
    awaited: CMD_NONE, src: '0, buf_byte: '0, reply: '0,
    line_kbd: 1'b0, line_aux: 1'b0
  };

  // Device data is masked while its interface is disabled.
  function automatic logic [5:0] kbc_live(kbc_state_t s);
    return s.pend & ~(s.mode[5:0] & (PD_KBD | PD_AUX));
  endfunction

  function automatic kbc_state_t kbc_drive_lines(kbc_state_t s);
    kbc_state_t r;
    r = s;
    r.line_kbd = 1'b0;
    r.line_aux = 1'b0;
    if ((s.status & ST_OBF) != '0) begin
      if ((s.status & ST_AUXOBF) != '0) begin
        r.line_aux = (s.mode & MD_AUXINT) != '0;
      end else begin
        r.line_kbd = ((s.mode & MD_KBDINT) != '0) && ((s.mode & MD_KBDOFF) == '0);
      end
    end
    return r;
  endfunction

  function automatic kbc_state_t kbc_clear_full(kbc_state_t s);
    kbc_state_t r;
    r = s;
    r.status = s.status & ~(ST_OBF | ST_AUXOBF);
    r.oport  = s.oport & ~(OP_OBF | OP_AUXOBF);
    return r;
  endfunction

  function automatic kbc_state_t kbc_choose_source(kbc_state_t s);
    kbc_state_t r;
    logic [5:0] p;
    p = kbc_live(s);
    r = kbc_clear_full(s);
    if (p != '0) begin
      r.status = r.status | ST_OBF;
      r.oport  = r.oport | OP_OBF;
      if ((p & PD_CKBD) != '0) begin
        r.src = SRC_CTL;
      end else if ((p & PD_CAUX) != '0) begin
        r.status = r.status | ST_AUXOBF;
        r.oport  = r.oport | OP_AUXOBF;
        r.src    = SRC_CTL;
      end else if ((p & PD_KBD) != '0) begin
        r.src = SRC_KBD;
      end else begin
        r.status = r.status | ST_AUXOBF;
        r.oport  = r.oport | OP_AUXOBF;
        r.src    = SRC_AUX;
      end
    end
    return kbc_drive_lines(r);
  endfunction

  function automatic kbc_state_t kbc_try_fill(kbc_state_t s);
    if (((s.status & ST_OBF) == '0) && (kbc_live(s) != '0)) begin
      return kbc_choose_source(s);
    end
    return s;
  endfunction

  function automatic kbc_state_t kbc_post_reply(kbc_state_t s, logic [7:0] b, logic aux);
    kbc_state_t r;
    r = s;
    r.reply = b;
    r.pend  = (s.pend & ~(PD_CKBD | PD_CAUX)) | (aux ? PD_CAUX : PD_CKBD);
    return kbc_try_fill(r);
  endfunction

endpackage

>>> design/kbc_step.sv
// Combinational next-state and result logic for one controller transaction.
module kbc_step (
  input  kbc_pkg::kbc_state_t state,
  input  kbc_pkg::kbc_in_t    item,
  output kbc_pkg::kbc_state_t state_nxt,
  output kbc_pkg::kbc_out_t   result
);
  import kbc_pkg::*;

  kbc_state_t s;
  logic [7:0] cmd;
  logic [7:0] rd;
  logic [7:0] snd;
  logic       rst_req;
  logic       ksv;
  logic       msv;
  logic       kf;
  logic       mf;

  always_comb begin
    s       = state;
    rd      = '0;
    snd     = '0;
    rst_req = 1'b0;
    ksv     = 1'b0;
    msv     = 1'b0;
    kf      = 1'b0;
    mf      = 1'b0;
    cmd     = item.data_byte;
    if ((item.data_byte & CMD_PULSE_BASE) == CMD_PULSE_BASE) begin
      cmd = item.data_byte[0] ? CMD_PULSE_NOP : CMD_PULSE_RST;
    end
    unique case (item.operation)
      OP_RD_STATUS: begin
        rd = s.status;
      end
      OP_RD_DATA: begin
        if ((s.status & ST_OBF) != '0) begin
          s = kbc_drive_lines(kbc_clear_full(s));
          if ((s.src & SRC_KBD) != '0) begin
            s.buf_byte = item.kbd_byte;
            kf = 1'b1;
          end else if ((s.src & SRC_AUX) != '0) begin
            s.buf_byte = item.mouse_byte;
            mf = 1'b1;
          end else if ((s.src & SRC_CTL) != '0) begin
            s.buf_byte = s.reply;
            s.pend = s.pend & ~(PD_CKBD | PD_CAUX);
            if (kbc_live(s) != '0) begin
              s = kbc_choose_source(s);
            end
          end
        end
        rd = s.buf_byte;
      end
      OP_WR_CMD: begin
        unique case (cmd) inside
          CMD_RD_MODE:   s = kbc_post_reply(s, s.mode, 1'b0);
          CMD_WR_MODE, CMD_WR_OPORT, CMD_WR_KBD_OB, CMD_WR_AUX_OB, CMD_WR_AUX:
            s.awaited = cmd;
          CMD_AUX_OFF:   s.mode = s.mode | MD_AUXOFF;
          CMD_AUX_ON: begin
            s.mode = s.mode & ~MD_AUXOFF;
            s = kbc_try_fill(s);
          end
          CMD_AUX_TEST, CMD_KBD_TEST: s = kbc_post_reply(s, TEST_OK, 1'b0);
          CMD_SELF_TEST: begin
            s.status = s.status | ST_SELFTEST;
            s = kbc_post_reply(s, SELF_TEST_OK, 1'b0);
          end
          CMD_KBD_OFF:   s.mode = s.mode | MD_KBDOFF;
          CMD_KBD_ON: begin
            s.mode = s.mode & ~MD_KBDOFF;
            s = kbc_try_fill(s);
          end
          CMD_RD_INPORT: s = kbc_post_reply(s, INPORT_VALUE, 1'b0);
          CMD_RD_OPORT:  s = kbc_post_reply(s, s.oport, 1'b0);
          CMD_A20_ON:    s.oport = s.oport | OP_A20;
          CMD_A20_OFF:   s.oport = s.oport & ~OP_A20;
          CMD_PULSE_RST: rst_req = 1'b1;
          default: begin
          end
        endcase
      end
      OP_WR_DATA: begin
        unique case (s.awaited)
          CMD_NONE: begin
            ksv    = 1'b1;
            snd    = item.data_byte;
            s.mode = s.mode & ~MD_KBDOFF;
            s = kbc_try_fill(s);
          end
          CMD_WR_MODE: begin
            s.mode = item.data_byte;
            s = kbc_try_fill(kbc_drive_lines(s));
          end
          CMD_WR_KBD_OB: s = kbc_post_reply(s, item.data_byte, 1'b0);
          CMD_WR_AUX_OB: s = kbc_post_reply(s, item.data_byte, 1'b1);
          CMD_WR_OPORT: begin
            s.oport = item.data_byte;
            rst_req = ~item.data_byte[0];
          end
          CMD_WR_AUX: begin
            msv    = 1'b1;
            snd    = item.data_byte;
            s.mode = s.mode & ~MD_AUXOFF;
            s = kbc_try_fill(s);
          end
          default: begin
          end
        endcase
        s.awaited = CMD_NONE;
      end
      OP_KBD_LEVEL, OP_AUX_LEVEL: begin
        if (item.operation == OP_KBD_LEVEL) begin
          s.pend = item.line_level ? (s.pend | PD_KBD) : (s.pend & ~PD_KBD);
        end else begin
          s.pend = item.line_level ? (s.pend | PD_AUX) : (s.pend & ~PD_AUX);
        end
        s = kbc_try_fill(s);
      end
      default: begin
      end
    endcase
  end

  assign state_nxt = s;

  assign result = '{
    read_value:       rd,
    kbd_irq:          s.line_kbd,
    aux_irq:          s.line_aux,
    a20_line:         s.oport[1],
    reset_request:    rst_req,
    kbd_send_valid:   ksv,
    mouse_send_valid: msv,
    send_byte:        snd,
    kbd_fetch:        kf,
    mouse_fetch:      mf,
    translate_enable: s.mode[6]
  };

endmodule

>>> design/ps2_keyboard_controller.sv
// Top level of the PS/2 keyboard and mouse controller with input and result registers.
//
// Each input transaction (status read, data read, command write, data write or a
// keyboard or mouse line change) produces exactly one result transaction. The
// controller accepts one transaction per clock cycle while the result channel is not
// stalled: an input register feeds a single pass of decode and state-update logic,
// and the result is registered. Throughput is limited only by the result channel;
// while a result waits for out_ready, the input register can still take one more
// transaction.
module ps2_keyboard_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kbc_pkg::kbc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kbc_pkg::kbc_out_t out_data
);
  import kbc_pkg::*;

  logic       in_valid_r;
  kbc_in_t    in_data_r;
  logic       out_valid_r;
  kbc_out_t   out_data_r;
  kbc_state_t state_r;
  kbc_state_t state_nxt;
  kbc_out_t   result;
  logic       advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  kbc_step u_step (
    .state     (state_r),
    .item      (in_data_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/kbc_checker.sv
// Port-level assertions for the PS/2 keyboard controller, bound to its top level.
module kbc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input kbc_pkg::kbc_out_t out_data
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_irq_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.kbd_irq && out_data.aux_irq))
    else $error("Both interrupt lines high in one result.");

  a_send_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.kbd_send_valid && out_data.mouse_send_valid) &&
                  (out_data.kbd_send_valid || out_data.mouse_send_valid ||
                   out_data.send_byte == 8'h00))
    else $error("Send byte inconsistent with send valids.");

  a_fetch_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.kbd_fetch && out_data.mouse_fetch) &&
                  !((out_data.kbd_fetch || out_data.mouse_fetch) &&
                    (out_data.kbd_send_valid || out_data.mouse_send_valid ||
                     out_data.reset_request)))
    else $error("Device fetch in a result that is not a plain data read.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result transaction changed while stalled.");

endmodule

bind ps2_keyboard_controller kbc_checker u_kbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/kbc_tb_pkg.sv
// Scoreboard class that predicts and checks the PS/2 keyboard controller results.
package kbc_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  import kbc_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam logic [7:0] MD_XLAT    = 8'h40;

  class kbc_scoreboard;
    logic [7:0] stat, mode, oport, awaiting, held, reply;
    logic [5:0] pend;
    logic [2:0] src;
    logic       irq_k, irq_m;
    kbc_out_t   expected_q[$];
    int unsigned mismatches, results_seen, reset_count, fetch_count, send_count;

    function new();
      stat = STATUS_RESET;
      mode = MODE_RESET;
      oport = OPORT_RESET;
      awaiting = CMD_NONE;
      held = '0;
      reply = '0;
      pend = '0;
      src = '0;
      irq_k = 1'b0;
      irq_m = 1'b0;
      mismatches = 0;
      results_seen = 0;
      reset_count = 0;
      fetch_count = 0;
      send_count = 0;
    endfunction

    function logic [5:0] live_flags();
      logic [5:0] p;
      p = pend;
      if ((mode & MD_KBDOFF) != 0) p = p & ~PD_KBD;
      if ((mode & MD_AUXOFF) != 0) p = p & ~PD_AUX;
      return p;
    endfunction

    function void update_irqs();
      irq_k = 1'b0;
      irq_m = 1'b0;
      if ((stat & ST_OBF) != 0) begin
        if ((stat & ST_AUXOBF) != 0) begin
          irq_m = (mode & MD_AUXINT) != 0;
        end else begin
          irq_k = ((mode & MD_KBDINT) != 0) && ((mode & MD_KBDOFF) == 0);
        end
      end
    endfunction

    function void empty_buffer();
      stat = stat & ~(ST_OBF | ST_AUXOBF);
      oport = oport & ~(OP_OBF | OP_AUXOBF);
    endfunction

    function void mark_aux();
      stat = stat | ST_AUXOBF;
      oport = oport | OP_AUXOBF;
    endfunction

    // Controller replies win over device data, keyboard over mouse.
    function void load_buffer();
      logic [5:0] p;
      p = live_flags();
      empty_buffer();
      if (p != 0) begin
        stat = stat | ST_OBF;
        oport = oport | OP_OBF;
        if ((p & PD_CKBD) != 0) begin
          src = SRC_CTL;
        end else if ((p & PD_CAUX) != 0) begin
          mark_aux();
          src = SRC_CTL;
        end else if ((p & PD_KBD) != 0) begin
          src = SRC_KBD;
        end else begin
          mark_aux();
          src = SRC_AUX;
        end
      end
      update_irqs();
    endfunction

    function void refill();
      if ((stat & ST_OBF) == 0 && live_flags() != 0) load_buffer();
    endfunction

    function void queue_reply(logic [7:0] b, bit aux);
      reply = b;
      pend = pend & ~(PD_CKBD | PD_CAUX);
      pend = pend | (aux ? PD_CAUX : PD_CKBD);
      refill();
    endfunction

    function void note_input(kbc_in_t t);
      kbc_out_t r;
      logic [7:0] c;
      logic [5:0] flag;
      r = '0;
      case (t.operation)
        OP_RD_STATUS: r.read_value = stat;
        OP_RD_DATA: begin
          if ((stat & ST_OBF) != 0) begin
            empty_buffer();
            update_irqs();
            if ((src & SRC_KBD) != 0) begin
              held = t.kbd_byte;
              r.kbd_fetch = 1'b1;
            end else if ((src & SRC_AUX) != 0) begin
              held = t.mouse_byte;
              r.mouse_fetch = 1'b1;
            end else if ((src & SRC_CTL) != 0) begin
              held = reply;
              pend = pend & ~(PD_CKBD | PD_CAUX);
              if (live_flags() != 0) load_buffer();
            end
          end
          r.read_value = held;
        end
        OP_WR_CMD: begin
          c = t.data_byte;
          if (c[7:4] == CMD_PULSE_BASE[7:4]) c = c[0] ? CMD_PULSE_NOP : CMD_PULSE_RST;
          case (c)
            CMD_RD_MODE: queue_reply(mode, 1'b0);
            CMD_WR_MODE, CMD_WR_OPORT, CMD_WR_KBD_OB, CMD_WR_AUX_OB, CMD_WR_AUX: awaiting = c;
            CMD_AUX_OFF: mode = mode | MD_AUXOFF;
            CMD_AUX_ON: begin
              mode = mode & ~MD_AUXOFF;
              refill();
            end
            CMD_AUX_TEST, CMD_KBD_TEST: queue_reply(TEST_OK, 1'b0);
            CMD_SELF_TEST: begin
              stat = stat | ST_SELFTEST;
              queue_reply(SELF_TEST_OK, 1'b0);
            end
            CMD_KBD_OFF: mode = mode | MD_KBDOFF;
            CMD_KBD_ON: begin
              mode = mode & ~MD_KBDOFF;
              refill();
            end
            CMD_RD_INPORT: queue_reply(INPORT_VALUE, 1'b0);
            CMD_RD_OPORT: queue_reply(oport, 1'b0);
            CMD_A20_ON: oport = oport | OP_A20;
            CMD_A20_OFF: oport = oport & ~OP_A20;
            CMD_PULSE_RST: r.reset_request = 1'b1;
            default: ;
          endcase
        end
        OP_WR_DATA: begin
          case (awaiting)
            CMD_NONE: begin
              r.kbd_send_valid = 1'b1;
              r.send_byte = t.data_byte;
              mode = mode & ~MD_KBDOFF;
              refill();
            end
            CMD_WR_MODE: begin
              mode = t.data_byte;
              update_irqs();
              refill();
            end
            CMD_WR_KBD_OB: queue_reply(t.data_byte, 1'b0);
            CMD_WR_AUX_OB: queue_reply(t.data_byte, 1'b1);
            CMD_WR_OPORT: begin
              oport = t.data_byte;
              r.reset_request = ~t.data_byte[0];
            end
            CMD_WR_AUX: begin
              r.mouse_send_valid = 1'b1;
              r.send_byte = t.data_byte;
              mode = mode & ~MD_AUXOFF;
              refill();
            end
            default: ;
          endcase
          awaiting = CMD_NONE;
        end
        OP_KBD_LEVEL, OP_AUX_LEVEL: begin
          flag = (t.operation == OP_KBD_LEVEL) ? PD_KBD : PD_AUX;
          pend = t.line_level ? (pend | flag) : (pend & ~flag);
          refill();
        end
        default: ;
      endcase
      r.kbd_irq = irq_k;
      r.aux_irq = irq_m;
      r.a20_line = (oport & OP_A20) != 0;
      r.translate_enable = (mode & MD_XLAT) != 0;
      if (r.reset_request) reset_count++;
      if (r.kbd_fetch || r.mouse_fetch) fetch_count++;
      if (r.kbd_send_valid || r.mouse_send_valid) send_count++;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(kbc_out_t got);
      kbc_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result transaction with nothing expected, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("kbd_irq", 8'(want.kbd_irq), 8'(got.kbd_irq));
      compare_field("aux_irq", 8'(want.aux_irq), 8'(got.aux_irq));
      compare_field("a20_line", 8'(want.a20_line), 8'(got.a20_line));
      compare_field("reset_request", 8'(want.reset_request), 8'(got.reset_request));
      compare_field("kbd_send_valid", 8'(want.kbd_send_valid), 8'(got.kbd_send_valid));
      compare_field("mouse_send_valid", 8'(want.mouse_send_valid),
                    8'(got.mouse_send_valid));
      compare_field("send_byte", want.send_byte, got.send_byte);
      compare_field("kbd_fetch", 8'(want.kbd_fetch), 8'(got.kbd_fetch));
      compare_field("mouse_fetch", 8'(want.mouse_fetch), 8'(got.mouse_fetch));
      compare_field("translate_enable", 8'(want.translate_enable),
                    8'(got.translate_enable));
    endfunction
  endclass

endpackage

>>> tb/ps2_keyboard_controller_tb.sv
// Top-level testbench that drives and checks the PS/2 keyboard controller.
module ps2_keyboard_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kbc_pkg::*;
  import kbc_tb_pkg::*;

  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  kbc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  kbc_out_t out_data;

  int unsigned tx_idle = 0;
  int unsigned rx_idle = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  kbc_scoreboard board = new();

  logic [7:0] known_cmds [0:16] = '{
    CMD_RD_MODE, CMD_WR_MODE, CMD_AUX_OFF, CMD_AUX_ON, CMD_AUX_TEST, CMD_SELF_TEST,
    CMD_KBD_TEST, CMD_KBD_OFF, CMD_KBD_ON, CMD_RD_INPORT, CMD_RD_OPORT, CMD_WR_OPORT,
    CMD_WR_KBD_OB, CMD_WR_AUX_OB, CMD_WR_AUX, CMD_A20_OFF, CMD_A20_ON
  };

  ps2_keyboard_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_input(in_data);
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
    out_ready <= rst_n && ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic kbc_in_t make_item(logic [2:0] op, logic [7:0] value, logic lvl);
    kbc_in_t t;
    t.operation = op;
    t.data_byte = value;
    t.line_level = lvl;
    t.kbd_byte = 8'($urandom);
    t.mouse_byte = 8'($urandom);
    return t;
  endfunction

  task automatic send_item(input kbc_in_t item);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  // Mostly command and data pairs or line events followed by reads, with some noise.
  task automatic random_traffic(int unsigned count);
    int unsigned done_items;
    int unsigned pick;
    logic [7:0] cmd;
    logic [7:0] value;
    logic [2:0] op;
    done_items = 0;
    while (done_items < count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        if ($urandom_range(9) == 0) begin
          cmd = 8'($urandom);
        end else if ($urandom_range(9) == 0) begin
          cmd = {CMD_PULSE_BASE[7:4], 4'($urandom)};
        end else begin
          cmd = known_cmds[5'($urandom_range(16))];
        end
        send_item(make_item(OP_WR_CMD, cmd, 1'($urandom)));
        done_items++;
        if ((cmd == CMD_WR_MODE || (cmd >= CMD_WR_OPORT && cmd <= CMD_WR_AUX))
            && $urandom_range(9) != 0) begin
          value = 8'($urandom);
          if (cmd == CMD_WR_MODE && $urandom_range(9) < 6) value = value & ~(MD_KBDOFF | MD_AUXOFF);
          send_item(make_item(OP_WR_DATA, value, 1'($urandom)));
          done_items++;
        end
      end else if (pick < 65) begin
        op = $urandom_range(1) ? OP_KBD_LEVEL : OP_AUX_LEVEL;
        send_item(make_item(op, 8'($urandom), $urandom_range(3) != 0));
        done_items++;
        repeat ($urandom_range(2)) begin
          send_item(make_item(OP_RD_DATA, 8'($urandom), 1'($urandom)));
          done_items++;
        end
      end else begin
        op = ($urandom_range(99) < 4) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        send_item(make_item(op, 8'($urandom), 1'($urandom)));
        if (op != OP_SPARE_6 && op != OP_SPARE_7) done_items++;
      end
    end
  endtask

  initial begin
    tx_idle = 24;
    rx_idle = 48;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_item(OP_RD_STATUS, 8'h00, 1'b0));
    send_item(make_item(OP_RD_DATA, 8'hFF, 1'b1));
    send_item(make_item(OP_WR_CMD, CMD_SELF_TEST, 1'b0));
    send_item(make_item(OP_RD_DATA, 8'h00, 1'b0));
    send_item(make_item(OP_WR_CMD, CMD_RD_MODE, 1'b0));
    send_item(make_item(OP_WR_CMD, CMD_WR_MODE, 1'b0));
    send_item(make_item(OP_WR_DATA, 8'hFF, 1'b0));
    send_item(make_item(OP_KBD_LEVEL, 8'h00, 1'b1));
    send_item(make_item(OP_WR_CMD, CMD_KBD_ON, 1'b0));
    send_item(make_item(OP_RD_DATA, 8'h00, 1'b0));
    send_item(make_item(OP_WR_CMD, CMD_WR_AUX_OB, 1'b0));
    send_item(make_item(OP_WR_DATA, 8'h00, 1'b0));
    send_item(make_item(OP_RD_STATUS, 8'h00, 1'b0));
    send_item(make_item(OP_WR_CMD, CMD_WR_OPORT, 1'b0));
    send_item(make_item(OP_WR_DATA, 8'hFE, 1'b0));
    send_item(make_item(OP_WR_CMD, CMD_A20_ON, 1'b0));
    send_item(make_item(OP_WR_CMD, CMD_PULSE_BASE, 1'b0));
    send_item(make_item(OP_WR_CMD, CMD_PULSE_NOP, 1'b0));
    send_item(make_item(OP_WR_CMD, CMD_WR_AUX, 1'b0));
    send_item(make_item(OP_WR_DATA, 8'h80, 1'b0));
    send_item(make_item(OP_WR_DATA, 8'h55, 1'b0));
    send_item(make_item(OP_AUX_LEVEL, 8'h00, 1'b1));
    send_item(make_item(OP_SPARE_6, 8'h00, 1'b1));
    send_item(make_item(OP_SPARE_7, 8'hFF, 1'b0));
    send_item(make_item(OP_WR_CMD, CMD_AUX_OFF, 1'b0));
    hold_until_drained();

    random_traffic(300);
    hold_until_drained();
    tx_idle = 48;
    rx_idle = 24;
    random_traffic(300);
    hold_until_drained();
    tx_idle = 0;
    rx_idle = 0;
    random_traffic(300);
    hold_until_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d transactions and checked %0d results with random handshake gaps.",
             sent, board.results_seen);
    $display("Seen %0d reset requests, %0d device fetches and %0d device sends.",
             board.reset_count, board.fetch_count, board.send_count);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/kbc_pkg.sv
design/kbc_step.sv
design/ps2_keyboard_controller.sv
design/kbc_checker.sv
tb/kbc_tb_pkg.sv
tb/ps2_keyboard_controller_tb.sv
